### hw/rtl/room_slot_relay_table_assert.svh
// Assertion macros for the room slot relay table.
`ifndef ROOM_SLOT_RELAY_TABLE_ASSERT_SVH
`define ROOM_SLOT_RELAY_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define RSRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RSRT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RSRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define RSRT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hw/rtl/rsrt_pkg.sv
package rsrt_pkg;

  localparam int NUM_ROOMS_DEF      = 16;
  localparam int SLOTS_PER_ROOM_DEF = 4;

  localparam int EP_W       = 48;
  localparam int ROOM_W     = 32;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 96;

  localparam logic [7:0]  MAGIC        = 8'h53;
  localparam logic [7:0]  VERSION      = 8'h01;
  localparam logic [7:0]  CMD_JOIN     = 8'h01;
  localparam logic [7:0]  CMD_HB       = 8'h03;
  localparam logic [7:0]  CMD_STATE    = 8'h04;
  localparam logic [7:0]  CMD_ACTION   = 8'h05;
  localparam logic [7:0]  CMD_DAMAGE   = 8'h06;
  localparam logic [7:0]  CMD_DISC     = 8'h08;
  localparam logic [11:0] MIN_LEN      = 12'd3;
  localparam logic [11:0] JOIN_MIN_LEN = 12'd8;
  localparam logic [7:0]  SLOT_NONE    = 8'hFF;

  typedef logic [1:0] send_kind_t;
  localparam send_kind_t KIND_JOIN = 2'd0;
  localparam send_kind_t KIND_ECHO = 2'd1;
  localparam send_kind_t KIND_FWD  = 2'd2;

  typedef logic [1:0] join_status_t;
  localparam join_status_t ST_OK         = 2'd0;
  localparam join_status_t ST_ROOM_FULL  = 2'd1;
  localparam join_status_t ST_TABLE_FULL = 2'd2;

  typedef logic [2:0] pkt_class_t;
  localparam pkt_class_t PK_NONE  = 3'd0;
  localparam pkt_class_t PK_JOIN  = 3'd1;
  localparam pkt_class_t PK_HB    = 3'd2;
  localparam pkt_class_t PK_RELAY = 3'd3;
  localparam pkt_class_t PK_DISC  = 3'd4;

  typedef logic [1:0] scan_sel_t;
  localparam scan_sel_t SCAN_MEMBER = 2'd0;
  localparam scan_sel_t SCAN_ROOM   = 2'd1;
  localparam scan_sel_t SCAN_SLOT   = 2'd2;

  typedef struct packed {
    logic         load;
    logic         scan_start;
    scan_sel_t    scan_sel;
    logic         room_commit;
    logic         wr_new;
    logic         wr_clr;
    logic         wr_disc;
    logic         emit;
    send_kind_t   emit_kind;
    join_status_t join_status;
    logic         fwd_rd;
  } rsrt_cmd_t;

  typedef struct packed {
    pkt_class_t pclass;
    logic       scan_done;
    logic       mem_found;
    logic       room_hit;
    logic       room_free;
    logic       got_valid;
    logic       need_clr;
    logic       pend_any;
    logic       out_busy;
  } rsrt_stat_t;

endpackage

### hw/rtl/room_slot_relay_table.sv
// Channel   Ports                 tdata (low bit up)                         tuser
// in        in_tvalid/in_tready   magic_byte, version_byte, packet_length,  cmd
//                                 src_endpoint, join_room, req_slot
// out       out_tvalid/out_tready dest_endpoint, join_status, grant_slot,    send_kind
//                                 reply_room; tlast = last_of_run
// One item at a time. Items that fail the header checks are dropped; others first scan the
// slot RAM for the sender. A join then scans the room key RAM and, unless the table is
// full, the room's slots, and commits, then clears the old slot when the sender leaves
// another slot. A relay scans the room's slots, then forwards to each other active
// member in turn.
// Reset clears room-used and slot-active flags and scan state at once; no clearing pass.
// A stalled output holds the block until the item is taken.
`include "room_slot_relay_table_assert.svh"

module room_slot_relay_table #(
  parameter int NUM_ROOMS      = rsrt_pkg::NUM_ROOMS_DEF,
  parameter int SLOTS_PER_ROOM = rsrt_pkg::SLOTS_PER_ROOM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // magic_byte, version_byte, packet_length, src_endpoint, join_room, req_slot
  input  logic [rsrt_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic [7:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // dest_endpoint, join_status, grant_slot, reply_room
  output logic [rsrt_pkg::OUT_DATA_W-1:0] out_tdata,
  // send_kind
  output logic [1:0]                      out_tuser,
  output logic                            out_tlast
);

  rsrt_pkg::rsrt_cmd_t  cmd;
  rsrt_pkg::rsrt_stat_t stat;
  logic                 in_fire;

  assign in_fire = in_tvalid && in_tready;

  rsrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rsrt_dp #(
    .NUM_ROOMS      (NUM_ROOMS),
    .SLOTS_PER_ROOM (SLOTS_PER_ROOM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_tdata),
    .in_user   (in_tuser),
    .out_ready (out_tready),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_user  (out_tuser),
    .out_last  (out_tlast)
  );

  `RSRT_ASSERT_IMP(a_idle_out_empty, clk, rst_n, in_fire, !out_tvalid, "item accepted with result pending")
  `RSRT_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_fire, !in_tready, "ready while item in work")
  `RSRT_ASSERT_IMP(a_single_last, clk, rst_n, out_tvalid && out_tuser != rsrt_pkg::KIND_FWD, out_tlast, "reply without tlast")
  `RSRT_ASSERT_IMP(a_slot_range, clk, rst_n, out_tvalid && out_tuser == rsrt_pkg::KIND_JOIN && out_tdata[49:48] == rsrt_pkg::ST_OK, out_tdata[57:50] < 8'(SLOTS_PER_ROOM), "granted slot out of range")

endmodule

### hw/rtl/rsrt_ram.sv
module rsrt_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                         rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/rsrt_ctrl.sv
module rsrt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  output logic                in_ready,
  input  rsrt_pkg::rsrt_stat_t stat,
  output rsrt_pkg::rsrt_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_MSCAN   = 4'd2;
  localparam logic [3:0] S_RSCAN   = 4'd3;
  localparam logic [3:0] S_SSCAN   = 4'd4;
  localparam logic [3:0] S_JCOMMIT = 4'd5;
  localparam logic [3:0] S_JCLR    = 4'd6;
  localparam logic [3:0] S_FRD     = 4'd7;
  localparam logic [3:0] S_FEMIT   = 4'd8;
  localparam logic [3:0] S_FWAIT   = 4'd9;
  localparam logic [3:0] S_OUT     = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.load        = in_fire;
    cmd.scan_sel    = rsrt_pkg::SCAN_MEMBER;
    cmd.emit_kind   = rsrt_pkg::KIND_JOIN;
    cmd.join_status = rsrt_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.pclass == rsrt_pkg::PK_NONE) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          cmd.scan_sel   = rsrt_pkg::SCAN_MEMBER;
          state_nxt      = S_MSCAN;
        end
      end
      S_MSCAN: begin
        if (stat.scan_done) begin
          if (stat.pclass == rsrt_pkg::PK_JOIN) begin
            cmd.scan_start = 1'b1;
            cmd.scan_sel   = rsrt_pkg::SCAN_ROOM;
            state_nxt      = S_RSCAN;
          end else if (!stat.mem_found) begin
            state_nxt = S_IDLE;
          end else if (stat.pclass == rsrt_pkg::PK_HB) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = rsrt_pkg::KIND_ECHO;
            state_nxt     = S_OUT;
          end else if (stat.pclass == rsrt_pkg::PK_DISC) begin
            cmd.wr_disc = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            cmd.scan_start = 1'b1;
            cmd.scan_sel   = rsrt_pkg::SCAN_SLOT;
            state_nxt      = S_SSCAN;
          end
        end
      end
      S_RSCAN: begin
        if (stat.scan_done) begin
          if (!stat.room_hit && !stat.room_free) begin
            cmd.emit        = 1'b1;
            cmd.join_status = rsrt_pkg::ST_TABLE_FULL;
            state_nxt       = S_OUT;
          end else begin
            cmd.scan_start = 1'b1;
            cmd.scan_sel   = rsrt_pkg::SCAN_SLOT;
            state_nxt      = S_SSCAN;
          end
        end
      end
      S_SSCAN: begin
        if (stat.scan_done) begin
          if (stat.pclass != rsrt_pkg::PK_JOIN) begin
            state_nxt = S_FRD;
          end else if (stat.got_valid) begin
            state_nxt = S_JCOMMIT;
          end else begin
            cmd.emit        = 1'b1;
            cmd.join_status = rsrt_pkg::ST_ROOM_FULL;
            state_nxt       = S_OUT;
          end
        end
      end
      S_JCOMMIT: begin
        cmd.room_commit = 1'b1;
        cmd.wr_new      = 1'b1;
        if (stat.need_clr) begin
          state_nxt = S_JCLR;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_JCLR: begin
        cmd.wr_clr = 1'b1;
        cmd.emit   = 1'b1;
        state_nxt  = S_OUT;
      end
      S_FRD: begin
        if (stat.pend_any) begin
          cmd.fwd_rd = 1'b1;
          state_nxt  = S_FEMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FEMIT: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = rsrt_pkg::KIND_FWD;
        state_nxt     = S_FWAIT;
      end
      S_FWAIT: begin
        if (!stat.out_busy) state_nxt = S_FRD;
      end
      S_OUT: begin
        if (!stat.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/rsrt_dp.sv
module rsrt_dp #(
  parameter int NUM_ROOMS      = rsrt_pkg::NUM_ROOMS_DEF,
  parameter int SLOTS_PER_ROOM = rsrt_pkg::SLOTS_PER_ROOM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [rsrt_pkg::IN_DATA_W-1:0]   in_data,
  input  logic [7:0]                       in_user,
  input  logic                             out_ready,
  input  rsrt_pkg::rsrt_cmd_t              cmd,
  output rsrt_pkg::rsrt_stat_t             stat,
  output logic                             out_valid,
  output logic [rsrt_pkg::OUT_DATA_W-1:0]  out_data,
  output rsrt_pkg::send_kind_t             out_user,
  output logic                             out_last
);

  localparam int NS  = NUM_ROOMS * SLOTS_PER_ROOM;
  localparam int SW  = NS > 1 ? $clog2(NS) : 1;
  localparam int RW  = NUM_ROOMS > 1 ? $clog2(NUM_ROOMS) : 1;
  localparam int PW  = $clog2(SLOTS_PER_ROOM);
  localparam int CW  = $clog2(NS + 1);
  localparam int EW  = rsrt_pkg::EP_W;
  localparam int RMW = rsrt_pkg::ROOM_W;

  logic [7:0]     cmd_r, magic_r, ver_r, pref_r;
  logic [11:0]    len_r;
  logic [EW-1:0]  ep_r;
  logic [RMW-1:0] room_r;
  rsrt_pkg::pkt_class_t pclass;

  logic [NUM_ROOMS-1:0] room_used_r;

  logic                busy_r, cmp_v_r;
  rsrt_pkg::scan_sel_t sel_r;
  logic [CW-1:0]       cnt_r, cmp_cnt_r, scan_len;
  logic [RW-1:0]       row_r, cmp_row_r;
  logic [PW-1:0]       col_r, cmp_col_r;
  logic                issue, scan_done;

  logic          mem_found_r;
  logic [SW-1:0] mg_idx_r;
  logic [RW-1:0] mg_room_r;
  logic [PW-1:0] mg_slot_r;

  logic          hit_r, free_r;
  logic [RW-1:0] hit_idx_r, free_idx_r, jroom;

  logic [SLOTS_PER_ROOM-1:0] act_r, pend_r, mg_bit, fsel_bit;
  logic                      same_r;
  logic [PW-1:0]             same_s_r, fsel_r, pick, low_free, got_s;
  logic                      free_any, pref_ok, got_valid;

  logic [RW-1:0] sroom;
  logic [SW-1:0] slot_base, newg, s_raddr, s_waddr;
  logic          s_we;
  logic [EW:0]   s_wdata, s_rdata;
  logic [RMW-1:0] key_rdata;

  logic [NS-1:0] slot_act_r;
  logic          rd_act_r;

  logic          rd_mem, rd_act;
  logic [EW-1:0] rd_ep;

  logic                       out_valid_r;
  rsrt_pkg::send_kind_t       kind_r;
  logic [EW-1:0]              dest_r;
  rsrt_pkg::join_status_t     status_r;
  logic [7:0]                 slot_r;
  logic [RMW-1:0]             rroom_r;
  logic                       last_r;

  always_comb begin
    pclass = rsrt_pkg::PK_NONE;
    if (len_r >= rsrt_pkg::MIN_LEN && magic_r == rsrt_pkg::MAGIC &&
        ver_r == rsrt_pkg::VERSION) begin
      unique case (cmd_r) inside
        rsrt_pkg::CMD_JOIN:
          pclass = (len_r >= rsrt_pkg::JOIN_MIN_LEN) ? rsrt_pkg::PK_JOIN : rsrt_pkg::PK_NONE;
        rsrt_pkg::CMD_HB:   pclass = rsrt_pkg::PK_HB;
        rsrt_pkg::CMD_STATE, rsrt_pkg::CMD_ACTION, rsrt_pkg::CMD_DAMAGE:
          pclass = rsrt_pkg::PK_RELAY;
        rsrt_pkg::CMD_DISC: pclass = rsrt_pkg::PK_DISC;
        default:            pclass = rsrt_pkg::PK_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_user;
      magic_r <= in_data[7:0];
      ver_r   <= in_data[15:8];
      len_r   <= in_data[27:16];
      ep_r    <= in_data[75:28];
      room_r  <= in_data[107:76];
      pref_r  <= in_data[115:108];
    end
  end

  always_comb begin
    case (sel_r)
      rsrt_pkg::SCAN_MEMBER: scan_len = CW'(NS);
      rsrt_pkg::SCAN_ROOM:   scan_len = CW'(NUM_ROOMS);
      default:               scan_len = CW'(SLOTS_PER_ROOM);
    endcase
  end

  assign issue     = busy_r && (cnt_r != scan_len);
  assign scan_done = busy_r && !issue && !cmp_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cmp_v_r <= 1'b0;
    end else begin
      cmp_v_r <= issue;
      if (cmd.scan_start) begin
        busy_r <= 1'b1;
      end else if (scan_done) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_cnt_r <= cnt_r;
    cmp_row_r <= row_r;
    cmp_col_r <= col_r;
    if (cmd.scan_start) begin
      sel_r <= cmd.scan_sel;
      cnt_r <= '0;
      row_r <= '0;
      col_r <= '0;
    end else if (issue) begin
      cnt_r <= cnt_r + 1'b1;
      if (col_r == PW'(SLOTS_PER_ROOM - 1)) begin
        col_r <= '0;
        row_r <= row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  assign rd_mem = s_rdata[EW];
  assign rd_act = rd_act_r;
  assign rd_ep  = s_rdata[EW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_found_r <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      same_r      <= 1'b0;
      act_r       <= '0;
    end else if (cmd.scan_start) begin
      case (cmd.scan_sel)
        rsrt_pkg::SCAN_MEMBER: mem_found_r <= 1'b0;
        rsrt_pkg::SCAN_ROOM: begin
          hit_r  <= 1'b0;
          free_r <= 1'b0;
        end
        default: begin
          same_r <= 1'b0;
          act_r  <= '0;
        end
      endcase
    end else if (cmp_v_r) begin
      case (sel_r)
        rsrt_pkg::SCAN_MEMBER: begin
          if (!mem_found_r && room_used_r[cmp_row_r] && rd_act && rd_mem && rd_ep == ep_r) begin
            mem_found_r <= 1'b1;
            mg_idx_r    <= cmp_cnt_r[SW-1:0];
            mg_room_r   <= cmp_row_r;
            mg_slot_r   <= cmp_col_r;
          end
        end
        rsrt_pkg::SCAN_ROOM: begin
          if (!hit_r && room_used_r[cmp_cnt_r[RW-1:0]] && key_rdata == room_r) begin
            hit_r     <= 1'b1;
            hit_idx_r <= cmp_cnt_r[RW-1:0];
          end
          if (!free_r && !room_used_r[cmp_cnt_r[RW-1:0]]) begin
            free_r     <= 1'b1;
            free_idx_r <= cmp_cnt_r[RW-1:0];
          end
        end
        default: begin
          if (room_used_r[sroom] && rd_act) begin
            act_r[cmp_cnt_r[PW-1:0]] <= 1'b1;
            if (!same_r && rd_ep == ep_r) begin
              same_r   <= 1'b1;
              same_s_r <= cmp_cnt_r[PW-1:0];
            end
          end
        end
      endcase
    end
  end

  assign jroom = hit_r ? hit_idx_r : free_idx_r;
  assign sroom = (pclass == rsrt_pkg::PK_JOIN) ? jroom : mg_room_r;
  assign slot_base = SW'(sroom) * SW'(SLOTS_PER_ROOM);

  always_comb begin
    free_any = 1'b0;
    low_free = '0;
    for (int s = SLOTS_PER_ROOM - 1; s >= 0; s--) begin
      if (!act_r[s]) begin
        free_any = 1'b1;
        low_free = PW'(s);
      end
    end
    pick = '0;
    for (int s = SLOTS_PER_ROOM - 1; s >= 0; s--) begin
      if (pend_r[s]) pick = PW'(s);
    end
  end

  assign pref_ok   = (pref_r < 8'(SLOTS_PER_ROOM)) && !act_r[pref_r[PW-1:0]];
  assign got_s     = same_r ? same_s_r : (pref_ok ? pref_r[PW-1:0] : low_free);
  assign got_valid = same_r || pref_ok || free_any;
  assign newg      = slot_base + SW'(got_s);
  assign mg_bit    = SLOTS_PER_ROOM'(1) << mg_slot_r;
  assign fsel_bit  = SLOTS_PER_ROOM'(1) << fsel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (scan_done && sel_r == rsrt_pkg::SCAN_SLOT) begin
      pend_r <= act_r & ~mg_bit;
    end else if (cmd.emit && cmd.emit_kind == rsrt_pkg::KIND_FWD) begin
      pend_r <= pend_r & ~fsel_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fwd_rd) fsel_r <= pick;
  end

  always_comb begin
    if (busy_r && sel_r == rsrt_pkg::SCAN_MEMBER) begin
      s_raddr = cnt_r[SW-1:0];
    end else if (busy_r) begin
      s_raddr = slot_base + SW'(cnt_r[PW-1:0]);
    end else begin
      s_raddr = slot_base + SW'(pick);
    end
  end

  assign s_we    = cmd.wr_new || cmd.wr_clr || cmd.wr_disc;
  assign s_waddr = cmd.wr_new ? newg : mg_idx_r;
  assign s_wdata = cmd.wr_new ? {1'b1, ep_r} : {1'b0, ep_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_act_r <= '0;
    end else if (cmd.wr_new) begin
      slot_act_r[newg] <= 1'b1;
    end else if (cmd.wr_disc) begin
      slot_act_r[mg_idx_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_act_r <= slot_act_r[s_raddr];
  end

  rsrt_ram #(.W(EW + 1), .DEPTH(NS)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  rsrt_ram #(.W(RMW), .DEPTH(NUM_ROOMS)) u_key_ram (
    .clk   (clk),
    .we    (cmd.room_commit && !hit_r),
    .waddr (jroom),
    .wdata (room_r),
    .raddr (cnt_r[RW-1:0]),
    .rdata (key_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      room_used_r <= '0;
    end else if (cmd.room_commit) begin
      room_used_r[jroom] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind_r   <= cmd.emit_kind;
      dest_r   <= ep_r;
      status_r <= rsrt_pkg::ST_OK;
      slot_r   <= '0;
      rroom_r  <= '0;
      last_r   <= 1'b1;
      case (cmd.emit_kind)
        rsrt_pkg::KIND_JOIN: begin
          status_r <= cmd.join_status;
          slot_r   <= (cmd.join_status == rsrt_pkg::ST_OK) ? 8'(got_s) : rsrt_pkg::SLOT_NONE;
          rroom_r  <= room_r;
        end
        rsrt_pkg::KIND_FWD: begin
          dest_r <= rd_ep;
          last_r <= ((pend_r & ~fsel_bit) == '0);
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_user  = kind_r;
  assign out_last  = last_r;
  assign out_data  = {6'd0, rroom_r, slot_r, status_r, dest_r};

  always_comb begin
    stat           = '0;
    stat.pclass    = pclass;
    stat.scan_done = scan_done;
    stat.mem_found = mem_found_r;
    stat.room_hit  = hit_r;
    stat.room_free = free_r;
    stat.got_valid = got_valid;
    stat.need_clr  = mem_found_r && (mg_idx_r != newg);
    stat.pend_any  = (pend_r != '0);
    stat.out_busy  = out_valid_r;
  end

endmodule
